// File: rtl/core/mscp_pkg.sv
package mscp_pkg;

  typedef enum logic [2:0] {
    PH_SCAN = 3'd0,
    PH_CODE = 3'd1,
    PH_SEQ  = 3'd2,
    PH_PIC  = 3'd3
  } phase_e;

  localparam logic [7:0] CODE_PACK     = 8'hBA;
  localparam logic [7:0] CODE_SYSTEM   = 8'hBB;
  localparam logic [7:0] CODE_SEQUENCE = 8'hB3;
  localparam logic [7:0] CODE_GOP      = 8'hB8;
  localparam logic [7:0] CODE_PICTURE  = 8'h00;
  localparam logic [7:0] PREFIX_ONE    = 8'h01;
  localparam logic [7:0] PREFIX_ZERO   = 8'h00;

  localparam logic [3:0] CLS_PACK     = 4'd0;
  localparam logic [3:0] CLS_SYSTEM   = 4'd1;
  localparam logic [3:0] CLS_SEQUENCE = 4'd2;
  localparam logic [3:0] CLS_GOP      = 4'd3;
  localparam logic [3:0] CLS_PICTURE  = 4'd4;
  localparam logic [3:0] CLS_SLICE    = 4'd5;
  localparam logic [3:0] CLS_AUDIO    = 4'd6;
  localparam logic [3:0] CLS_VIDEO    = 4'd7;
  localparam logic [3:0] CLS_UNKNOWN  = 4'd8;

  localparam logic [1:0] SEQ_LAST_COUNT = 2'd3;
  localparam logic [1:0] PIC_LAST_COUNT = 2'd1;
  localparam logic [1:0] ZERO_RUN_MAX   = 2'd2;

  localparam int unsigned TDATA_W = 56;
  localparam int unsigned TUSER_W = 4;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] zero_run;
    logic [7:0] held_code;
    logic [1:0] count;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  picture_kind;
    logic [15:0] rate_millifps;
    logic [3:0]  rate_code;
    logic [11:0] frame_height;
    logic [11:0] frame_width;
    logic [7:0]  code_value;
  } result_data_t;

  typedef struct packed {
    result_data_t data;
    logic [3:0]   code_class;
  } result_t;

endpackage

// File: rtl/core/mscp_result.sv
module mscp_result (
  input  mscp_pkg::parse_state_t  state_i,
  input  logic [2:0][7:0]         hdr_i,
  input  logic [7:0]              byte_i,
  output logic                    valid_o,
  output mscp_pkg::result_t       result_o
);
  import mscp_pkg::*;

  function automatic logic [3:0] classify(input logic [7:0] c);
    logic [3:0] cls;
    unique case (c) inside
      CODE_PACK:      cls = CLS_PACK;
      CODE_SYSTEM:    cls = CLS_SYSTEM;
      CODE_SEQUENCE:  cls = CLS_SEQUENCE;
      CODE_GOP:       cls = CLS_GOP;
      CODE_PICTURE:   cls = CLS_PICTURE;
      [8'h01:8'hAF]:  cls = CLS_SLICE;
      [8'hC0:8'hDF]:  cls = CLS_AUDIO;
      [8'hE0:8'hEF]:  cls = CLS_VIDEO;
      default:        cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [3:0] rc);
    logic [15:0] r;
    case (rc)
      4'd1:    r = 16'd23976;
      4'd2:    r = 16'd24000;
      4'd3:    r = 16'd25000;
      4'd4:    r = 16'd29970;
      4'd5:    r = 16'd30000;
      4'd6:    r = 16'd50000;
      4'd7:    r = 16'd59940;
      4'd8:    r = 16'd60000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  logic [2:0] pic_type;

  assign pic_type = byte_i[5:3];

  always_comb begin
    valid_o  = 1'b0;
    result_o = '0;
    unique case (state_i.phase)
      PH_CODE: begin
        if (byte_i != CODE_SEQUENCE && byte_i != CODE_PICTURE) begin
          valid_o                  = 1'b1;
          result_o.data.code_value = byte_i;
          result_o.code_class      = classify(byte_i);
        end
      end
      PH_SEQ: begin
        if (state_i.count == SEQ_LAST_COUNT) begin
          valid_o                     = 1'b1;
          result_o.data.code_value    = state_i.held_code;
          result_o.code_class         = CLS_SEQUENCE;
          result_o.data.frame_width   = {hdr_i[0], hdr_i[1][7:4]};
          result_o.data.frame_height  = {hdr_i[1][3:0], hdr_i[2]};
          result_o.data.rate_code     = byte_i[3:0];
          result_o.data.rate_millifps = rate_lookup(byte_i[3:0]);
        end
      end
      PH_PIC: begin
        if (state_i.count == PIC_LAST_COUNT) begin
          valid_o                  = 1'b1;
          result_o.data.code_value = state_i.held_code;
          result_o.code_class      = CLS_PICTURE;
          if (pic_type >= 3'd1 && pic_type <= 3'd3) begin
            result_o.data.picture_kind = pic_type[1:0];
          end
        end
      end
      default: begin
        valid_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/mpeg_start_code_parser_unit.sv
// MPEG-1 program stream start-code parser.
// Slave channel: one stream byte per transaction on s_axis_tdata_i[7:0].
// Master channel: one transaction per start code found (00 00 01 xx).
// Codes are reported on the code byte, a sequence header on its fourth
// header byte and a picture on its second header byte; other bytes give
// nothing. tuser carries the code class, tdata the code and header fields.
// Throughput is one byte per cycle while the output register is not stalled:
// the parser state and the result are computed in one pass from the state
// registers and the incoming byte. The result shows on the master side in
// the cycle after the byte that completes it, held in the output register.
// When the receiver stalls with a result held, tready drops and no byte is
// taken until the output register is read; the next byte can be taken in
// the same cycle that the held result leaves.
// Reset clears the parser to prefix scanning and empties the output
// register; header byte storage is not cleared and is always written
// before it is read.
module mpeg_start_code_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] data_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] code_value, [19:8] frame_width, [31:20] frame_height,
  // [35:32] rate_code, [51:36] rate_millifps, [53:52] picture_kind, [55:54] zero
  output logic [mscp_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic [mscp_pkg::TUSER_W-1:0]  m_axis_tuser_o   // [3:0] code_class
);
  import mscp_pkg::*;

  parse_state_t    st_q, st_d;
  logic [2:0][7:0] hdr_q;
  logic            hdr_we;
  logic            res_valid;
  result_t         res;
  logic            accept;
  logic            out_valid_q;
  result_t         out_q;

  mscp_result u_result (
    .state_i  (st_q),
    .hdr_i    (hdr_q),
    .byte_i   (s_axis_tdata_i),
    .valid_o  (res_valid),
    .result_o (res)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    st_d   = st_q;
    hdr_we = 1'b0;
    unique case (st_q.phase)
      PH_CODE: begin
        st_d.held_code = s_axis_tdata_i;
        st_d.zero_run  = 2'd0;
        st_d.count     = 2'd0;
        if (s_axis_tdata_i == CODE_SEQUENCE) begin
          st_d.phase = PH_SEQ;
        end else if (s_axis_tdata_i == CODE_PICTURE) begin
          st_d.phase = PH_PIC;
        end else begin
          st_d.phase = PH_SCAN;
        end
      end
      PH_SEQ: begin
        if (st_q.count != SEQ_LAST_COUNT) begin
          hdr_we     = 1'b1;
          st_d.count = st_q.count + 2'd1;
        end else begin
          st_d.count = 2'd0;
          st_d.phase = PH_SCAN;
        end
      end
      PH_PIC: begin
        if (st_q.count != PIC_LAST_COUNT) begin
          hdr_we     = 1'b1;
          st_d.count = PIC_LAST_COUNT;
        end else begin
          st_d.count = 2'd0;
          st_d.phase = PH_SCAN;
        end
      end
      default: begin
        st_d.phase = PH_SCAN;
        if (s_axis_tdata_i == PREFIX_ONE && st_q.zero_run >= ZERO_RUN_MAX) begin
          st_d.zero_run = 2'd0;
          st_d.phase    = PH_CODE;
        end else if (s_axis_tdata_i == PREFIX_ZERO) begin
          if (st_q.zero_run < ZERO_RUN_MAX) begin
            st_d.zero_run = st_q.zero_run + 2'd1;
          end
        end else begin
          st_d.zero_run = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_SCAN, zero_run: 2'd0, held_code: 8'd0, count: 2'd0};
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hdr_we) begin
      hdr_q[st_q.count] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.data};
  assign m_axis_tuser_o  = out_q.code_class;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_SCAN) |-> !res_valid)
    else $error("result raised while scanning for a prefix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_CODE) |-> (st_q.zero_run == 2'd0))
    else $error("zero run not cleared after prefix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == CLS_SEQUENCE)
      |-> (m_axis_tdata_o[7:0] == CODE_SEQUENCE))
    else $error("sequence class without sequence code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != CLS_PICTURE)
      |-> (m_axis_tdata_o[53:52] == 2'd0))
    else $error("picture kind set on a non-picture result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_valid) |=> m_axis_tvalid_o)
    else $error("result lost at output register");
`endif

endmodule

// File: tb/mpeg_start_code_parser_unit_test.sv
`timescale 1ns / 100ps

module mpeg_start_code_parser_unit_test;
  import mscp_pkg::*;

  localparam logic [7:0] SLICE_LO = 8'h01;
  localparam logic [7:0] SLICE_HI = 8'hAF;
  localparam logic [7:0] AUDIO_LO = 8'hC0;
  localparam logic [7:0] AUDIO_HI = 8'hDF;
  localparam logic [7:0] VIDEO_LO = 8'hE0;
  localparam logic [7:0] VIDEO_HI = 8'hEF;
  localparam logic [7:0] RSVD_LO  = 8'hB0;
  localparam logic [7:0] RSVD_HI  = 8'hBF;
  localparam logic [7:0] EXT_LO   = 8'hF0;
  localparam logic [7:0] EXT_HI   = 8'hFF;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 10;
  localparam int MAX_REPORTS      = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [TDATA_W-1:0]   m_tdata;
  logic [TUSER_W-1:0]   m_tuser;

  mpeg_start_code_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  logic [7:0] stream_bytes [$];
  result_t    expected_codes [$];
  bit         byte_taken;
  int         src_idle_pct;
  int         snk_idle_pct;
  int         hold_req;
  int         hold_ack;
  int         hold_left;
  int         fail_count;

  // parser shadow state
  phase_e     parse_phase;
  logic [1:0] zeros_seen;
  logic [7:0] code_held;
  logic [7:0] hdr [3];
  logic [1:0] hdr_count;

  function automatic logic [3:0] classify_code(input logic [7:0] c);
    if (c == CODE_PACK) return CLS_PACK;
    if (c == CODE_SYSTEM) return CLS_SYSTEM;
    if (c == CODE_SEQUENCE) return CLS_SEQUENCE;
    if (c == CODE_GOP) return CLS_GOP;
    if (c == CODE_PICTURE) return CLS_PICTURE;
    if (c >= SLICE_LO && c <= SLICE_HI) return CLS_SLICE;
    if (c >= AUDIO_LO && c <= AUDIO_HI) return CLS_AUDIO;
    if (c >= VIDEO_LO && c <= VIDEO_HI) return CLS_VIDEO;
    return CLS_UNKNOWN;
  endfunction

  function automatic logic [15:0] frame_rate_millifps(input logic [3:0] rc);
    case (rc)
      4'd1: return 16'd23976;
      4'd2: return 16'd24000;
      4'd3: return 16'd25000;
      4'd4: return 16'd29970;
      4'd5: return 16'd30000;
      4'd6: return 16'd50000;
      4'd7: return 16'd59940;
      4'd8: return 16'd60000;
      default: return 16'd0;
    endcase
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    result_t    r;
    logic [2:0] pic_type;
    r = '0;
    case (parse_phase)
      PH_CODE: begin
        code_held  = b;
        zeros_seen = '0;
        hdr_count  = '0;
        if (b == CODE_SEQUENCE) begin
          parse_phase = PH_SEQ;
        end else if (b == CODE_PICTURE) begin
          parse_phase = PH_PIC;
        end else begin
          parse_phase       = PH_SCAN;
          r.data.code_value = b;
          r.code_class      = classify_code(b);
          expected_codes.push_back(r);
        end
      end
      PH_SEQ: begin
        if (hdr_count < SEQ_LAST_COUNT) begin
          hdr[hdr_count] = b;
          hdr_count      = hdr_count + 2'd1;
        end else begin
          r.data.code_value    = code_held;
          r.code_class         = CLS_SEQUENCE;
          r.data.frame_width   = {hdr[0], hdr[1][7:4]};
          r.data.frame_height  = {hdr[1][3:0], hdr[2]};
          r.data.rate_code     = b[3:0];
          r.data.rate_millifps = frame_rate_millifps(b[3:0]);
          expected_codes.push_back(r);
          hdr_count   = '0;
          parse_phase = PH_SCAN;
        end
      end
      PH_PIC: begin
        if (hdr_count < PIC_LAST_COUNT) begin
          hdr[0]    = b;
          hdr_count = PIC_LAST_COUNT;
        end else begin
          pic_type          = b[5:3];
          r.data.code_value = code_held;
          r.code_class      = CLS_PICTURE;
          r.data.picture_kind = (pic_type >= 3'd1 && pic_type <= 3'd3) ? pic_type[1:0] : 2'd0;
          expected_codes.push_back(r);
          hdr_count   = '0;
          parse_phase = PH_SCAN;
        end
      end
      default: begin
        parse_phase = PH_SCAN;
        if (b == PREFIX_ONE && zeros_seen >= ZERO_RUN_MAX) begin
          zeros_seen  = '0;
          parse_phase = PH_CODE;
        end else if (b == PREFIX_ZERO) begin
          if (zeros_seen < ZERO_RUN_MAX) zeros_seen = zeros_seen + 2'd1;
        end else begin
          zeros_seen = '0;
        end
      end
    endcase
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", what);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // source: present the next byte once the current one is taken
  always @(negedge clk_i) begin : source
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      if (stream_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tdata  <= stream_bytes.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink: random backpressure, plus a long hold on request
  always @(negedge clk_i) begin : sink
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = SINK_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t      want;
    result_data_t got;
    if (rst_ni) begin
      byte_taken = s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = m_tdata[53:0];
        if (expected_codes.size() == 0) begin
          note_failure($sformatf("unexpected result: tdata %h tuser %h", m_tdata, m_tuser));
        end else begin
          want = expected_codes.pop_front();
          if (got.code_value !== want.data.code_value ||
              m_tuser !== want.code_class ||
              got.frame_width !== want.data.frame_width ||
              got.frame_height !== want.data.frame_height ||
              got.rate_code !== want.data.rate_code ||
              got.rate_millifps !== want.data.rate_millifps ||
              got.picture_kind !== want.data.picture_kind ||
              m_tdata[55:54] !== 2'b00) begin
            note_failure($sformatf(
              "mismatch: expected tdata %h tuser %h, got tdata %h tuser %h",
              {2'b00, want.data}, want.code_class, m_tdata, m_tuser));
          end
        end
      end
      if (byte_taken) parse_byte(s_tdata);
    end
  end

  task automatic push_bytes(input logic [7:0] b [$]);
    foreach (b[i]) stream_bytes.push_back(b[i]);
  endtask

  task automatic push_start_code(input logic [7:0] code);
    push_bytes('{PREFIX_ZERO, PREFIX_ZERO, PREFIX_ONE, code});
  endtask

  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    case ($urandom_range(8))
      0: c = CODE_PACK;
      1: c = CODE_SYSTEM;
      2: c = CODE_SEQUENCE;
      3: c = CODE_GOP;
      4: c = CODE_PICTURE;
      5: c = 8'($urandom_range(SLICE_HI, SLICE_LO));
      6: c = 8'($urandom_range(AUDIO_HI, AUDIO_LO));
      7: c = 8'($urandom_range(VIDEO_HI, VIDEO_LO));
      default: begin
        c = 8'($urandom_range(RSVD_HI, RSVD_LO));
        if (c == CODE_PACK || c == CODE_SYSTEM || c == CODE_SEQUENCE || c == CODE_GOP)
          c = 8'($urandom_range(EXT_HI, EXT_LO));
      end
    endcase
    return c;
  endfunction

  task automatic push_random_stream(input int n);
    int         target;
    int         sel;
    logic [7:0] code;
    target = stream_bytes.size() + n;
    while (stream_bytes.size() < target) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        repeat ($urandom_range(2)) stream_bytes.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(2)) stream_bytes.push_back(PREFIX_ZERO);
        code = pick_code();
        push_start_code(code);
        if (code == CODE_SEQUENCE) begin
          repeat (4) stream_bytes.push_back(8'($urandom_range(255)));
        end else if (code == CODE_PICTURE) begin
          repeat (2) stream_bytes.push_back(8'($urandom_range(255)));
        end
      end else if (sel < 85) begin
        repeat ($urandom_range(4, 1)) stream_bytes.push_back(8'($urandom_range(255)));
      end else begin
        // zero run of one to three bytes ended by 01 or another nonzero byte; may form a prefix
        repeat ($urandom_range(3, 1)) stream_bytes.push_back(PREFIX_ZERO);
        if ($urandom_range(1)) stream_bytes.push_back(PREFIX_ONE);
        else stream_bytes.push_back(8'($urandom_range(255, 2)));
      end
    end
  endtask

  task automatic wait_drained();
    while (stream_bytes.size() != 0 || s_tvalid || expected_codes.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    byte_taken   = 1'b0;
    hold_req     = 0;
    hold_ack     = 0;
    hold_left    = 0;
    fail_count   = 0;
    src_idle_pct = 30;
    snk_idle_pct = 30;
    parse_phase  = PH_SCAN;
    zeros_seen   = '0;
    code_held    = '0;
    hdr_count    = '0;
    rst_ni       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, overlapping zeros, prefix inside header, rescan after code
    push_bytes('{8'hFF, PREFIX_ZERO});
    push_start_code(CODE_PACK);
    push_start_code(CODE_SEQUENCE);
    push_bytes('{PREFIX_ZERO, PREFIX_ZERO, PREFIX_ONE, 8'hFF});
    push_start_code(CODE_PICTURE);
    push_bytes('{PREFIX_ZERO, PREFIX_ONE, PREFIX_ONE, CODE_SYSTEM});
    wait_drained();

    // long sink hold while the source keeps offering
    push_random_stream(550);
    @(posedge clk_i);
    hold_req++;
    wait_drained();

    // no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_random_stream(550);
    wait_drained();

    src_idle_pct = 30;
    snk_idle_pct = 30;
    push_random_stream(550);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && expected_codes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
